>>> rtl/rabs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rabs_pkg
// Shared constants and stage types for the running average background
// subtractor.
// ----------------------------------------------------------------------------
package rabs_pkg;

  localparam int FRAME_PIXELS  = 262144;
  localparam int FRACTION_BITS = 8;

  localparam int PIX_W  = 8;
  localparam int CH_W   = PIX_W + FRACTION_BITS;
  localparam int NUM_CH = 3;
  localparam int BG_W   = NUM_CH * CH_W;
  localparam int POS_W  = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;

  localparam int GAIN_W      = 17;
  localparam int STEP_SHIFT  = 16;
  localparam int PROD_W      = CH_W + GAIN_W;
  localparam int DIFF_W      = CH_W + 1;
  localparam logic [GAIN_W-1:0] WEIGHT_ONE = GAIN_W'(65536);
  localparam logic [PIX_W-1:0]  PIX_MAX    = '1;

  localparam int GRAY_SUM_W = 23;
  localparam int GRAY_SHIFT = 14;
  localparam int GRAY_R_WT  = 4899;
  localparam int GRAY_G_WT  = 9617;
  localparam int GRAY_B_WT  = 1868;
  localparam int GRAY_RND   = 8192;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef logic [NUM_CH-1:0][PIX_W-1:0] pix_vec_t;
  typedef logic [NUM_CH-1:0][CH_W-1:0]  bg_vec_t;
  typedef logic [NUM_CH-1:0][PROD_W-1:0] prod_vec_t;

  typedef struct packed {
    logic              load;
    logic              color;
    logic [POS_W-1:0]  pos;
    pix_vec_t          px;
    logic [GAIN_W-1:0] gain;
  } s1_t;

  typedef struct packed {
    logic              load;
    logic [POS_W-1:0]  pos;
    pix_vec_t          px;
    logic [GAIN_W-1:0] gain;
    bg_vec_t           bg;
  } s2_t;

  typedef struct packed {
    logic              load;
    logic [POS_W-1:0]  pos;
    pix_vec_t          px;
    bg_vec_t           bg;
    logic [NUM_CH-1:0] ge;
    prod_vec_t         prod;
  } s3_t;

endpackage

>>> rtl/rabs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rabs_ram
// Generic single write port, single read port RAM with registered read.
// A read at the address being written returns the old data.
// ----------------------------------------------------------------------------
module rabs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/running_average_background_subtract.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// running_average_background_subtract
// Per-pixel exponential running average background with absolute difference
// output, colour or grey.
// ----------------------------------------------------------------------------
// usage
//   input words carry one bgr pixel, frame_start, restart and the keep weight;
//   output words carry the three saturated absolute differences.
//   both channels use valid/stall; a word moves when valid is high and stall
//   low. cfg_wr_en writes color_mode; write it only while the block is idle.
//   throughput is one pixel per cycle while in_stall is low, set by the
//   single background ram with one read and one write port. ram read, grey
//   conversion, blend multiply, round and write back lead to out_valid.
//   a pixel whose background entry is still in the three-stage read-modify-
//   write window is held off with in_stall until that entry is written, which
//   only occurs on very short frames or back-to-back frame starts.
//   results queue in an 8-word fifo; in_stall rises once 8 words are
//   outstanding, so a stalled receiver stops the input, the pipeline then
//   drains into the fifo, and nothing is lost.
//   reset empties the pipeline and fifo, sets colour mode, and makes the first
//   frame a loading frame; the ram needs no clearing.
// ----------------------------------------------------------------------------
module running_average_background_subtract (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic                        cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [rabs_pkg::PIX_W-1:0]  in_blue,
  input  logic [rabs_pkg::PIX_W-1:0]  in_green,
  input  logic [rabs_pkg::PIX_W-1:0]  in_red,
  input  logic                        in_frame_start,
  input  logic                        in_restart,
  input  logic [rabs_pkg::GAIN_W-1:0] in_keep_weight,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rabs_pkg::PIX_W-1:0]  out_diff_blue,
  output logic [rabs_pkg::PIX_W-1:0]  out_diff_green,
  output logic [rabs_pkg::PIX_W-1:0]  out_diff_red
);

  localparam int PW = rabs_pkg::POS_W;
  localparam int FB = rabs_pkg::FRACTION_BITS;

  // control state
  logic          color_mode_r;
  logic          bg_valid_r;
  logic          loading_r;
  logic [PW-1:0] pixel_pos_r;

  logic          in_acc;
  logic          out_acc;
  logic [PW-1:0] cur_pos;
  logic [PW-1:0] pos_nxt;
  logic          load_now;
  logic [rabs_pkg::GAIN_W-1:0] w_sat;
  logic          hazard;

  // pipeline
  logic            v1_r, v2_r, v3_r;
  rabs_pkg::s1_t   s1_r, s1_nxt;
  rabs_pkg::s2_t   s2_r, s2_nxt;
  rabs_pkg::s3_t   s3_r, s3_nxt;

  logic [rabs_pkg::BG_W-1:0] ram_rdata;
  logic [rabs_pkg::BG_W-1:0] ram_wdata;

  logic [rabs_pkg::GRAY_SUM_W-1:0] gray_sum;
  logic [rabs_pkg::PIX_W-1:0]      gray;

  rabs_pkg::bg_vec_t  bg_new;
  rabs_pkg::pix_vec_t diff;

  // output fifo
  rabs_pkg::pix_vec_t                fifo_mem_r [rabs_pkg::FIFO_DEPTH];
  logic [rabs_pkg::FIFO_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [rabs_pkg::FIFO_CNT_W-1:0]   fifo_cnt_r, credit_r;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  always_comb begin
    cur_pos  = in_frame_start ? '0 : pixel_pos_r;
    pos_nxt  = (cur_pos == PW'(rabs_pkg::FRAME_PIXELS - 1)) ? '0 : cur_pos + PW'(1);
    load_now = in_frame_start ? (in_restart || !bg_valid_r) : loading_r;
    w_sat    = (in_keep_weight > rabs_pkg::WEIGHT_ONE) ? rabs_pkg::WEIGHT_ONE
                                                       : in_keep_weight;
    hazard   = (v1_r && (s1_r.pos == cur_pos)) ||
               (v2_r && (s2_r.pos == cur_pos)) ||
               (v3_r && (s3_r.pos == cur_pos));
    in_stall = (credit_r == rabs_pkg::FIFO_CNT_W'(rabs_pkg::FIFO_DEPTH)) || hazard;

    s1_nxt.load  = load_now;
    s1_nxt.color = color_mode_r;
    s1_nxt.pos   = cur_pos;
    s1_nxt.px    = {in_red, in_green, in_blue};
    s1_nxt.gain  = rabs_pkg::WEIGHT_ONE - w_sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_mode_r <= 1'b1;
      bg_valid_r   <= 1'b0;
      loading_r    <= 1'b1;
      pixel_pos_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        color_mode_r <= cfg_wr_data;
        if (cfg_wr_data != color_mode_r) begin
          bg_valid_r <= 1'b0;
        end
      end
      if (in_acc) begin
        pixel_pos_r <= pos_nxt;
        if (in_frame_start) begin
          loading_r  <= load_now;
          bg_valid_r <= 1'b1;
        end
      end
    end
  end

  rabs_ram #(
    .WIDTH (rabs_pkg::BG_W),
    .DEPTH (rabs_pkg::FRAME_PIXELS)
  ) u_bg_ram (
    .clk   (clk),
    .we    (v3_r),
    .waddr (s3_r.pos),
    .wdata (ram_wdata),
    .raddr (cur_pos),
    .rdata (ram_rdata)
  );

  // stage 1: grey conversion, ram data arrives
  always_comb begin
    gray_sum = rabs_pkg::GRAY_SUM_W'(rabs_pkg::GRAY_R_WT)
                 * rabs_pkg::GRAY_SUM_W'(s1_r.px[2])
             + rabs_pkg::GRAY_SUM_W'(rabs_pkg::GRAY_G_WT)
                 * rabs_pkg::GRAY_SUM_W'(s1_r.px[1])
             + rabs_pkg::GRAY_SUM_W'(rabs_pkg::GRAY_B_WT)
                 * rabs_pkg::GRAY_SUM_W'(s1_r.px[0])
             + rabs_pkg::GRAY_SUM_W'(rabs_pkg::GRAY_RND);
    gray = gray_sum[rabs_pkg::GRAY_SHIFT +: rabs_pkg::PIX_W];

    s2_nxt.load = s1_r.load;
    s2_nxt.pos  = s1_r.pos;
    s2_nxt.px   = s1_r.color ? s1_r.px : {gray, gray, gray};
    s2_nxt.gain = s1_r.gain;
    s2_nxt.bg   = ram_rdata;
  end

  // stage 2: magnitude of the error times the gain
  always_comb begin
    logic [rabs_pkg::CH_W-1:0] big;
    logic [rabs_pkg::CH_W-1:0] mag;
    s3_nxt.load = s2_r.load;
    s3_nxt.pos  = s2_r.pos;
    s3_nxt.px   = s2_r.px;
    s3_nxt.bg   = s2_r.bg;
    for (int c = 0; c < rabs_pkg::NUM_CH; c++) begin
      big = rabs_pkg::CH_W'(s2_r.px[c]) << FB;
      s3_nxt.ge[c] = (big >= s2_r.bg[c]);
      mag = s3_nxt.ge[c] ? (big - s2_r.bg[c]) : (s2_r.bg[c] - big);
      s3_nxt.prod[c] = rabs_pkg::PROD_W'(mag) * rabs_pkg::PROD_W'(s2_r.gain);
    end
  end

  // stage 3: round the step, update, difference and saturate
  always_comb begin
    logic [rabs_pkg::CH_W-1:0]   big;
    logic [rabs_pkg::PROD_W-1:0] rnd;
    logic [rabs_pkg::CH_W-1:0]   step;
    logic [rabs_pkg::CH_W-1:0]   dmag;
    logic [rabs_pkg::DIFF_W-1:0] r;
    for (int c = 0; c < rabs_pkg::NUM_CH; c++) begin
      big  = rabs_pkg::CH_W'(s3_r.px[c]) << FB;
      rnd  = s3_r.prod[c] + (rabs_pkg::PROD_W'(1) << (rabs_pkg::STEP_SHIFT - 1));
      step = rnd[rabs_pkg::STEP_SHIFT +: rabs_pkg::CH_W];
      if (s3_r.load) begin
        bg_new[c] = big;
      end else if (s3_r.ge[c]) begin
        bg_new[c] = s3_r.bg[c] + step;
      end else begin
        bg_new[c] = s3_r.bg[c] - step;
      end
      dmag = (big >= bg_new[c]) ? (big - bg_new[c]) : (bg_new[c] - big);
      r    = (rabs_pkg::DIFF_W'(dmag) + (rabs_pkg::DIFF_W'(1) << (FB - 1))) >> FB;
      if (s3_r.load) begin
        diff[c] = '0;
      end else if (r > rabs_pkg::DIFF_W'(rabs_pkg::PIX_MAX)) begin
        diff[c] = rabs_pkg::PIX_MAX;
      end else begin
        diff[c] = r[rabs_pkg::PIX_W-1:0];
      end
    end
  end

  assign ram_wdata = bg_new;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_acc;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    s1_r <= s1_nxt;
    s2_r <= s2_nxt;
    s3_r <= s3_nxt;
  end

  // result fifo with credit count of outstanding words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
      credit_r   <= '0;
    end else begin
      if (v3_r) begin
        wr_ptr_r <= wr_ptr_r + rabs_pkg::FIFO_PTR_W'(1);
      end
      if (out_acc) begin
        rd_ptr_r <= rd_ptr_r + rabs_pkg::FIFO_PTR_W'(1);
      end
      fifo_cnt_r <= fifo_cnt_r + rabs_pkg::FIFO_CNT_W'(v3_r)
                               - rabs_pkg::FIFO_CNT_W'(out_acc);
      credit_r   <= credit_r + rabs_pkg::FIFO_CNT_W'(in_acc)
                             - rabs_pkg::FIFO_CNT_W'(out_acc);
    end
    if (v3_r) begin
      fifo_mem_r[wr_ptr_r] <= diff;
    end
  end

  assign out_valid      = (fifo_cnt_r != '0);
  assign out_diff_blue  = fifo_mem_r[rd_ptr_r][0];
  assign out_diff_green = fifo_mem_r[rd_ptr_r][1];
  assign out_diff_red   = fifo_mem_r[rd_ptr_r][2];

  // checks
  a_credit_bound : assert property (@(posedge clk) disable iff (!rst_n)
    credit_r <= rabs_pkg::FIFO_CNT_W'(rabs_pkg::FIFO_DEPTH))
    else $error("outstanding word count over fifo depth");

  a_fifo_le_credit : assert property (@(posedge clk) disable iff (!rst_n)
    fifo_cnt_r <= credit_r)
    else $error("fifo holds more words than are outstanding");

  a_no_rmw_overlap : assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && v2_r) |-> (s1_r.pos != s2_r.pos))
    else $error("two pixels of one entry inside the read-modify-write window");

  a_push_follows_accept : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> ##2 v3_r)
    else $error("accepted pixel did not reach write back");

endmodule
